/* rtl/gtg_pkg.sv */
// Package for the go-to-goal controller: widths, register indexes, CORDIC table,
// and the structs passed between the front end, the queue and the back end.
// No dependencies.
package gtg_pkg;

  localparam int CordicSteps = 16;
  localparam int GuardBits   = 8;
  localparam int CordW       = 28;
  localparam int AngW        = 20;
  localparam int QueueDepth  = 4;
  localparam int QueueAw     = 2;

  localparam logic [AngW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic [16:0]     CordGain  = 17'd39797;

  localparam logic [1:0] RegDistTol = 2'd0;
  localparam logic [1:0] RegAngTol  = 2'd1;
  localparam logic [1:0] RegLinGain = 2'd2;
  localparam logic [1:0] RegAngGain = 2'd3;

  typedef logic signed [CordW-1:0] cord_t;
  typedef logic signed [AngW-1:0]  ang_t;

  typedef struct packed {
    logic              valid;
    cord_t             x;
    cord_t             y;
    ang_t              z;
    logic signed [15:0] heading;
  } cord_stage_t;

  // Result of one vectoring pass, handed from the front end to the back end.
  typedef struct packed {
    logic               valid;
    logic signed [15:0] heading;
    logic [CordW-1:0]   xmag;
    ang_t               z;
  } vec_item_t;

  typedef struct packed {
    logic signed [19:0] fwd;
    logic signed [20:0] turn;
    logic               arrived;
  } result_t;

  function automatic ang_t atan_q16(input int i);
    case (i)
      0:  atan_q16 = 20'sd51472;
      1:  atan_q16 = 20'sd30385;
      2:  atan_q16 = 20'sd16055;
      3:  atan_q16 = 20'sd8150;
      4:  atan_q16 = 20'sd4091;
      5:  atan_q16 = 20'sd2047;
      6:  atan_q16 = 20'sd1024;
      7:  atan_q16 = 20'sd512;
      8:  atan_q16 = 20'sd256;
      9:  atan_q16 = 20'sd128;
      10: atan_q16 = 20'sd64;
      11: atan_q16 = 20'sd32;
      12: atan_q16 = 20'sd16;
      13: atan_q16 = 20'sd8;
      14: atan_q16 = 20'sd4;
      15: atan_q16 = 20'sd2;
      16: atan_q16 = 20'sd1;
      default: atan_q16 = '0;
    endcase
  endfunction

endpackage

/* rtl/gtg_front.sv */
// Front end: forms dx/dy, quadrant pre-rotation, pipelined CORDIC vectoring.
// Depends on gtg_pkg. Advances only when enabled (en_i).
module gtg_front import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic signed [15:0] current_x_i,
  input  logic signed [15:0] current_y_i,
  input  logic signed [15:0] current_heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic               goal_valid_i,
  output vec_item_t          item_o
);

  cord_stage_t stg_q [CordicSteps+1];
  cord_stage_t stg_d [CordicSteps+1];

  logic signed [16:0] dx, dy;
  logic signed [17:0] px, py;

  always_comb begin
    dx = 17'(goal_x_i) - 17'(current_x_i);
    dy = 17'(goal_y_i) - 17'(current_y_i);
    stg_d[0].z = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        px = 18'(dy); py = -18'(dx); stg_d[0].z = HalfPiQ16;
      end else begin
        px = -18'(dy); py = 18'(dx); stg_d[0].z = -HalfPiQ16;
      end
    end else begin
      px = 18'(dx); py = 18'(dy);
    end
    stg_d[0].valid   = in_valid_i & goal_valid_i;
    stg_d[0].x       = CordW'(px) <<< GuardBits;
    stg_d[0].y       = CordW'(py) <<< GuardBits;
    stg_d[0].heading = current_heading_i;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_it
    always_comb begin
      stg_d[i+1] = stg_q[i];
      if (stg_q[i].y >= 0) begin
        stg_d[i+1].x = stg_q[i].x + (stg_q[i].y >>> i);
        stg_d[i+1].y = stg_q[i].y - (stg_q[i].x >>> i);
        stg_d[i+1].z = stg_q[i].z + atan_q16(i);
      end else begin
        stg_d[i+1].x = stg_q[i].x - (stg_q[i].y >>> i);
        stg_d[i+1].y = stg_q[i].y + (stg_q[i].x >>> i);
        stg_d[i+1].z = stg_q[i].z - atan_q16(i);
      end
    end
  end

  for (genvar i = 0; i <= CordicSteps; i++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_q[i].valid <= 1'b0;
      end else if (en_i) begin
        stg_q[i] <= stg_d[i];
      end
    end
  end

  assign item_o.valid   = stg_q[CordicSteps].valid;
  assign item_o.heading = stg_q[CordicSteps].heading;
  assign item_o.xmag    = stg_q[CordicSteps].x;
  assign item_o.z       = stg_q[CordicSteps].z;

endmodule

/* rtl/gtg_back.sv */
// Back end: gain correction, tolerance tests, speed and turn products, saturation.
// Depends on gtg_pkg. Three register stages, advanced by en_i.
module gtg_back import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  vec_item_t          item_i,
  input  logic [15:0]        dist_tol_i,
  input  logic [15:0]        ang_tol_i,
  input  logic [11:0]        lin_gain_i,
  input  logic [11:0]        ang_gain_i,
  output logic               out_valid_o,
  output result_t            res_o
);

  // stage 1: distance product
  logic               v1_q, g1_q;
  logic [44:0]        prod1_q;
  logic signed [17:0] err1_q;
  logic signed [18:0] err_d;
  logic signed [AngW:0] zr;

  always_comb begin
    zr    = (AngW+1)'(item_i.z) + 21'sd4;
    err_d = 19'(zr >>> 3) - 19'(item_i.heading);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_q    <= item_i.valid;
      prod1_q <= 45'(item_i.xmag) * 45'(CordGain);
      err1_q  <= 18'(err_d);
    end
  end

  // stage 2: distance, compares, gain products
  logic        v2_q, g2_q, far2_q, turn2_q;
  logic [21:0] dist_v;
  logic [33:0] fprod2_q;
  logic signed [30:0] tprod2_q;
  logic [17:0] mag;

  always_comb begin
    dist_v = 22'((prod1_q + 45'(1 << 23)) >> 24);
    mag    = err1_q[17] ? 18'(-err1_q) : 18'(err1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g2_q     <= g1_q;
      far2_q   <= dist_v > 22'(dist_tol_i);
      turn2_q  <= mag > 18'(ang_tol_i);
      fprod2_q <= 34'(lin_gain_i) * 34'(dist_v);
      tprod2_q <= 31'(signed'({1'b0, ang_gain_i})) * 31'(err1_q);
    end
  end

  // stage 3: round, saturate, select
  logic [33:0]        fr;
  logic signed [30:0] tr;
  logic signed [19:0] fsat;
  logic signed [20:0] tsat;
  result_t            res_d;

  always_comb begin
    fr = (fprod2_q + 34'd128) >> 8;
    tr = (tprod2_q + 31'sd128) >>> 8;
    fsat = (fr > 34'd524287) ? 20'sd524287 : 20'(fr);
    if (tr > 31'sd1048575) tsat = 21'sd1048575;
    else if (tr < -31'sd1048576) tsat = -21'sd1048576;
    else tsat = 21'(tr);
    res_d.fwd     = '0;
    res_d.turn    = '0;
    res_d.arrived = 1'b0;
    if (g2_q) begin
      if (far2_q) begin
        res_d.fwd = fsat;
        if (turn2_q) res_d.turn = tsat;
      end else begin
        res_d.arrived = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      out_valid_o <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) res_o <= res_d;
  end

`ifndef SYNTH
  a_arr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.arrived |-> (res_o.fwd == 0 && res_o.turn == 0))
    else $error("arrived with nonzero command");
  a_fwd_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.fwd[19] || !out_valid_o)
    else $error("negative forward speed");
  a_v_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> out_valid_o == $past(v2_q))
    else $error("pipeline valid lost");
`endif

endmodule

/* rtl/gtg_queue.sv */
// Output queue for results; registered storage with valid count.
// Depends on gtg_pkg.
module gtg_queue import gtg_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  result_t wdata_i,
  input  logic    rd_i,
  output result_t rdata_o,
  output logic    empty_o,
  output logic [QueueAw:0] count_o
);

  result_t mem_q [QueueDepth];
  logic [QueueAw-1:0] wp_q, rp_q;
  logic [QueueAw:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QueueAw+1)'(wr_i) - (QueueAw+1)'(rd_i);
    end
  end
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == 0);
  assign count_o = cnt_q;

`ifndef SYNTH
  a_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> (cnt_q < (QueueAw+1)'(QueueDepth) || rd_i))
    else $error("queue overflow");
  a_no_udf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> cnt_q != 0)
    else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_i && !rd_i) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("count mismatch");
`endif

endmodule

/* rtl/go_to_goal_controller.sv */
// Top level of the go-to-goal controller: CORDIC front end, arithmetic back end,
// output queue. Depends on gtg_pkg, gtg_front, gtg_back, gtg_queue.
//
//  channel | handshake          | payload
//  input   | push / full        | current_*, goal_*
//  result  | pop / empty        | forward_speed_o, turn_rate_o, arrived_o
//  config  | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// One item per cycle unless the pipeline is halted (17 CORDIC stages, 3 back-end stages).
// The whole pipeline advances together and halts only when the 4-entry output
// queue is full, a result waits at the last stage and pop is low (full then high).
// Reset loads register defaults and empties the pipeline and queue.
module go_to_goal_controller import gtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] current_x_i,
  input  logic signed [15:0] current_y_i,
  input  logic signed [15:0] current_heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic               goal_valid_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [19:0] forward_speed_o,
  output logic signed [20:0] turn_rate_o,
  output logic               arrived_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);

  logic [15:0] dist_tol_q, ang_tol_q;
  logic [11:0] lin_gain_q, ang_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_tol_q <= 16'd205;
      ang_tol_q  <= 16'd82;
      lin_gain_q <= 12'd384;
      ang_gain_q <= 12'd1536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDistTol: dist_tol_q <= cfg_data_i;
        RegAngTol:  ang_tol_q  <= cfg_data_i;
        RegLinGain: lin_gain_q <= cfg_data_i[11:0];
        RegAngGain: ang_gain_q <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic      en, push_ok, out_v, q_empty;
  vec_item_t item;
  result_t   res, qout;
  logic [QueueAw:0] cnt;

  // advance whenever the queue has room, is being popped, or no result waits at the final stage
  assign en      = (cnt < (QueueAw+1)'(QueueDepth)) || (pop && !q_empty) || !out_v;
  assign full    = !en;
  assign push_ok = push && en;

  gtg_front u_front (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(push_ok),
    .current_x_i, .current_y_i, .current_heading_i, .goal_x_i, .goal_y_i,
    .goal_valid_i, .item_o(item)
  );

  logic [CordicSteps:0] vpipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vpipe_q <= '0;
    else if (en) vpipe_q <= {vpipe_q[CordicSteps-1:0], push_ok};
  end

  gtg_back u_back (
    .clk_i, .rst_ni, .en_i(en), .in_valid_i(vpipe_q[CordicSteps]), .item_i(item),
    .dist_tol_i(dist_tol_q), .ang_tol_i(ang_tol_q),
    .lin_gain_i(lin_gain_q), .ang_gain_i(ang_gain_q),
    .out_valid_o(out_v), .res_o(res)
  );

  gtg_queue u_queue (
    .clk_i, .rst_ni, .wr_i(out_v && en), .wdata_i(res),
    .rd_i(pop && !q_empty), .rdata_o(qout), .empty_o(q_empty), .count_o(cnt)
  );

  assign empty           = q_empty;
  assign forward_speed_o = qout.fwd;
  assign turn_rate_o     = qout.turn;
  assign arrived_o       = qout.arrived;

`ifndef SYNTH
  a_full_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v && !en) |=> $stable(res))
    else $error("result changed while stalled");
  a_qfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cnt == (QueueAw+1)'(QueueDepth))
    else $error("stall with queue room");
  a_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item.valid |-> vpipe_q[CordicSteps])
    else $error("item without slot");
`endif

endmodule

/* tb/tb_go_to_goal_controller.sv */
// Self-checking bench for go_to_goal_controller: directed and random poses and targets through
// the push/full side, results checked against a bit-exact CORDIC predictor.
// Depends on gtg_pkg and the controller RTL.
module tb_go_to_goal_controller;
  import gtg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] cx, cy, hd, gx, gy;
    logic               gv;
  } pose_req_t;

  typedef struct {
    logic signed [19:0] fwd;
    logic signed [20:0] turn;
    logic               arrived;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full, empty;
  logic pop = 1'b0;
  logic signed [15:0] cx = '0, cy = '0, hd = '0, gx = '0, gy = '0;
  logic gv = 1'b0;
  logic signed [19:0] fwd_o;
  logic signed [20:0] turn_o;
  logic arrived_o;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [15:0] cfg_data = '0;

  go_to_goal_controller u_dut (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .current_x_i(cx), .current_y_i(cy), .current_heading_i(hd),
    .goal_x_i(gx), .goal_y_i(gy), .goal_valid_i(gv),
    .empty(empty), .pop(pop),
    .forward_speed_o(fwd_o), .turn_rate_o(turn_o), .arrived_o(arrived_o),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pose_req_t pose_q[$];
  cmd_t      cmd_q[$];
  longint    dist_tol = 205, ang_tol = 82, lin_gain = 384, ang_gain = 1536;
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        quiet_tail = 0;
  bit        hold_rx = 0;
  int        tx_gap = 0, rx_gap = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_step(int i);
    longint t[17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2, 1};
    return i < 17 ? t[i] : 0;
  endfunction

  function automatic cmd_t predict_cmd(pose_req_t p);
    cmd_t   c;
    longint dx, dy, x, y, z, xs, ys, dist_v, brg, err, mag;
    c.fwd = '0; c.turn = '0; c.arrived = 1'b0;
    if (p.gv) begin
      dx = longint'(p.gx) - longint'(p.cx);
      dy = longint'(p.gy) - longint'(p.cy);
      z = 0;
      if (dx < 0) begin
        if (dy >= 0) begin x = dy; y = -dx; z = 102944; end
        else begin x = -dy; y = dx; z = -102944; end
      end else begin
        x = dx; y = dy;
      end
      x = x * 256; y = y * 256;
      for (int i = 0; i < CordicSteps; i++) begin
        xs = fshift(x, i); ys = fshift(y, i);
        if (y >= 0) begin x += ys; y -= xs; z += atan_step(i); end
        else begin x -= ys; y += xs; z -= atan_step(i); end
      end
      dist_v = rshift(x * 39797, 24);
      brg = rshift(z, 3);
      if (dist_v > dist_tol) begin
        err = brg - longint'(p.hd);
        mag = err < 0 ? -err : err;
        c.fwd = 20'(clip(rshift(lin_gain * dist_v, 8), -524288, 524287));
        if (mag > ang_tol)
          c.turn = 21'(clip(rshift(ang_gain * err, 8), -1048576, 1048575));
      end else begin
        c.arrived = 1'b1;
      end
    end
    return c;
  endfunction

  // driver
  always @(posedge clk) begin
    if (push && !full) begin
      cmd_q.push_back(predict_cmd(pose_q.pop_front()));
    end
    if (push && full) begin
    end else if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      push <= 1'b0;
    end else if (pose_q.size() > 0) begin
      if (!quiet_tail && push && !full && $urandom_range(0, 15) == 0) begin
        tx_gap <= $urandom_range(1, 15);
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        cx <= pose_q[0].cx; cy <= pose_q[0].cy; hd <= pose_q[0].hd;
        gx <= pose_q[0].gx; gy <= pose_q[0].gy; gv <= pose_q[0].gv;
      end
    end else begin
      push <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    cmd_t e;
    if (pop && !empty) begin
      if (cmd_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result fwd=%0d turn=%0d", fwd_o, turn_o);
      end else begin
        e = cmd_q.pop_front();
        if (fwd_o !== e.fwd || turn_o !== e.turn || arrived_o !== e.arrived) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp fwd=%0d turn=%0d arr=%0b got fwd=%0d turn=%0d arr=%0b",
                     e.fwd, e.turn, e.arrived, fwd_o, turn_o, arrived_o);
        end
      end
    end
    if (hold_rx) begin
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      pop <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
      rx_gap <= $urandom_range(1, 15);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_pose(logic signed [15:0] a, b, h, c, d, logic v);
    pose_req_t p;
    p.cx = a; p.cy = b; p.hd = h; p.gx = c; p.gy = d; p.gv = v;
    pose_q.push_back(p);
  endtask

  task automatic add_random(int n);
    logic signed [15:0] a, b;
    repeat (n) begin
      a = pick16(); b = pick16();
      if ($urandom_range(0, 3) == 0)
        add_pose(a, b, pick16(), 16'(a + 16'($urandom_range(0, 600)) - 16'd300),
                 16'(b + 16'($urandom_range(0, 600)) - 16'd300),
                 $urandom_range(0, 7) != 0);
      else
        add_pose(a, b, pick16(), pick16(), pick16(), $urandom_range(0, 7) != 0);
    end
  endtask

  task automatic drain();
    while (pose_q.size() > 0 || push || cmd_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegDistTol: dist_tol = val;
      RegAngTol:  ang_tol = val;
      RegLinGain: lin_gain = val & 16'hfff;
      RegAngGain: ang_gain = val & 16'hfff;
      default: ;
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    add_pose(0, 0, 0, 0, 0, 1);
    add_pose(0, 0, 0, 100, 0, 1);
    add_pose(0, 0, 0, 5000, 0, 0);
    add_pose(0, 0, 0, 5000, 0, 1);
    add_pose(0, 0, 0, 5000, 40, 1);
    add_pose(0, 0, 0, -5000, 3000, 1);
    add_pose(0, 0, 0, -5000, -3000, 1);
    add_pose(0, 0, 0, 0, -5000, 1);
    add_pose(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1);
    add_pose(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 1);
    add_pose(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 1);
    add_pose(-1, -1, -1, -1, -1, 1);
    add_pose(0, 0, 16'sh8000, -4000, 1, 1);
    add_random(300);
    // long receiver hold so the output queue fills and full rises
    hold_rx = 1;
    repeat (200) @(posedge clk);
    hold_rx = 0;
    drain();
    write_reg(RegDistTol, 16'hffff); write_reg(RegAngTol, 16'hffff);
    write_reg(RegLinGain, 16'hfff);  write_reg(RegAngGain, 16'hfff);
    add_random(400); drain();
    write_reg(RegDistTol, 0); write_reg(RegAngTol, 0);
    write_reg(RegLinGain, 0); write_reg(RegAngGain, 0);
    add_random(300); drain();
    write_reg(RegDistTol, 16'($urandom_range(0, 4000)));
    write_reg(RegAngTol, 16'($urandom_range(0, 4000)));
    write_reg(RegLinGain, 16'($urandom));
    write_reg(RegAngGain, 16'($urandom));
    add_random(500); drain();
    quiet_tail = 1;
    add_random(300); drain();
    if (mismatches == 0 && cmd_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/gtg_pkg.sv
rtl/gtg_front.sv
rtl/gtg_back.sv
rtl/gtg_queue.sv
rtl/go_to_goal_controller.sv
tb/tb_go_to_goal_controller.sv
